// ===== src/dsse_pkg.sv =====
// Shared constants, stage type and segment code table for the decimal seven-segment encoder.
package dsse_pkg;

  localparam int VALUE_WIDTH = 20;
  localparam int DIGITS      = 6;
  localparam int BCD_WIDTH   = 4 * DIGITS;

  localparam logic [7:0] SEG_BLANK = 8'h00;

  typedef struct packed {
    logic                   valid;
    logic [BCD_WIDTH-1:0]   bcd;
    logic [VALUE_WIDTH-1:0] bits;
  } dsse_stage_t;

  // Active-high codes, bit 0 is segment a, bit 7 unused
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

// ===== src/decimal_seven_segment_encoder_unit.sv =====
// Top level of the six-digit decimal seven-segment encoder.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | value[19:0]
//   out     | out_valid / out_ready| low_digits_word[31:0], high_digits_word[15:0]
//
// A chain of VALUE_WIDTH shift-add-3 cells turns one value bit into BCD per cell,
// then the segment register adds one more stage.
// One transaction per cycle is accepted while the output is empty or being taken.
// When out_valid is high and out_ready low, the whole chain holds and in_ready drops.
// Reset (synchronous, active high) clears every cell's valid bit; no clearing pass.
module decimal_seven_segment_encoder_unit
  import dsse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            low_digits_word,
  output logic [15:0]            high_digits_word
);

  dsse_stage_t chain [VALUE_WIDTH+1];
  logic        advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  assign chain[0] = '{valid: in_valid, bcd: '0, bits: value};

  for (genvar g = 0; g < VALUE_WIDTH; g++) begin : g_cell
    dsse_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (advance),
      .d   (chain[g]),
      .q   (chain[g+1])
    );
  end

  dsse_seg u_seg (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .d_valid   (chain[VALUE_WIDTH].valid),
    .d_bcd     (chain[VALUE_WIDTH].bcd),
    .valid     (out_valid),
    .low_word  (low_digits_word),
    .high_word (high_digits_word)
  );

  // The chain only stalls for a result that is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  // Every digit leaving the chain must be a proper decimal digit
  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    chain[VALUE_WIDTH].valid |->
      (chain[VALUE_WIDTH].bcd[3:0]   <= 4'd9) && (chain[VALUE_WIDTH].bcd[7:4]   <= 4'd9) &&
      (chain[VALUE_WIDTH].bcd[11:8]  <= 4'd9) && (chain[VALUE_WIDTH].bcd[15:12] <= 4'd9) &&
      (chain[VALUE_WIDTH].bcd[19:16] <= 4'd9) && (chain[VALUE_WIDTH].bcd[23:20] <= 4'd9))
    else $error("BCD digit out of range at end of chain");

endmodule

// ===== src/dsse_cell.sv =====
// One shift-add-3 cell of the binary to BCD chain: takes in one value bit per cell.
module dsse_cell
  import dsse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  dsse_stage_t d,
  output dsse_stage_t q
);

  logic                   valid;
  logic [BCD_WIDTH-1:0]   bcd;
  logic [VALUE_WIDTH-1:0] bits;
  logic [BCD_WIDTH-1:0]   adj;

  // Digits of 5 or more get +3 so the doubling carries decimally; the carry out
  // of the top digit is dropped, which gives the value modulo one million.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (d.bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = d.bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = d.bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bcd  <= {adj[BCD_WIDTH-2:0], d.bits[VALUE_WIDTH-1]};
      bits <= {d.bits[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  assign q = '{valid: valid, bcd: bcd, bits: bits};

endmodule

// ===== src/dsse_seg.sv =====
// Output register: maps the six BCD digits to segment bytes and packs the two words.
module dsse_seg
  import dsse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 d_valid,
  input  logic [BCD_WIDTH-1:0] d_bcd,
  output logic                 valid,
  output logic [31:0]          low_word,
  output logic [15:0]          high_word
);

  logic [8*DIGITS-1:0] segs;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      segs[8*i +: 8] = seg_code(d_bcd[4*i +: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      low_word  <= segs[31:0];
      high_word <= segs[47:32];
    end
  end

endmodule
